[rtl/core/batch_ascending_sorter_macros.svh]
// Assertion macros for the batch ascending sorter.
// Used by the top level only; depends on nothing.
`ifndef BATCH_ASCENDING_SORTER_MACROS_SVH
`define BATCH_ASCENDING_SORTER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define BAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bas_pkg.sv]
// Shared types and constants of the batch ascending sorter.
// Depends on nothing; the interfaces, the cell and the top level import it.
package bas_pkg;

  localparam int SORT_DEPTH = 64;
  localparam int VALUE_W    = 31;
  localparam int COUNT_W    = $clog2(SORT_DEPTH + 1);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } bas_state_t;

  // Broadcast control for the row of cells
  typedef struct packed {
    logic               insert;
    logic               shift;
    logic [VALUE_W-1:0] x;
  } bas_cell_ctl_t;

endpackage

[rtl/core/bas_if.sv]
// Valid/ready channel interfaces of the batch ascending sorter.
// Depends on bas_pkg for the payload widths.
interface bas_in_if import bas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface bas_out_if import bas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sorted_value;
  logic               last_res;
  logic               overflow;

  modport source (output valid, output sorted_value, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_res, input overflow,
                  output ready);
endinterface

[rtl/core/bas_cell.sv]
// One cell of the insertion row: holds one stored value.
// Depends on bas_pkg for the control struct and widths.
module bas_cell import bas_pkg::*; (
  input  logic                clk,
  input  bas_cell_ctl_t       ctl,
  input  logic                valid,
  input  logic                fill,
  input  logic                prev_gt,
  input  logic [VALUE_W-1:0]  prev_value,
  input  logic [VALUE_W-1:0]  next_value,
  output logic                gt,
  output logic [VALUE_W-1:0]  value
);

  logic [VALUE_W-1:0] value_next;

  assign gt = valid && (value > ctl.x);

  always_comb begin
    value_next = value;
    if (ctl.shift) begin
      value_next = next_value;
    end else if (ctl.insert) begin
      // take the left neighbor if it moves up, else take the new value if this cell moves up or is the first free one
      if (prev_gt) begin
        value_next = prev_value;
      end else if (gt || fill) begin
        value_next = ctl.x;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

[rtl/core/batch_ascending_sorter.sv]
// Top level of the batch ascending sorter: control, cell row, output register.
// Depends on bas_pkg, bas_if, bas_cell and batch_ascending_sorter_macros.svh.
//
//   channel | dir | transaction payload                  | handshake
//   --------+-----+--------------------------------------+-------------
//   src     | in  | value[30:0], last                    | valid/ready
//   dst     | out | sorted_value[30:0], last_res, overflow | valid/ready
//
// During loading each kept transaction is placed by one compare in every cell
// of the row, and entries above it move up by one cell.
// A batch of kept items is emitted one result per transfer, smallest first, as
// the row shifts toward cell 0; src.ready stays low during emission.
// Output stalls hold the row; the output register lets loading of the next
// batch start while the final result still waits.
// Synchronous active-high reset clears the count, overflow flag, state and
// output valid; stored values are not reset.
`include "batch_ascending_sorter_macros.svh"

module batch_ascending_sorter import bas_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bas_in_if.sink       src,
  bas_out_if.source    dst
);

  bas_state_t          state, state_next;
  logic [COUNT_W-1:0]  count, count_next;
  logic                overflow_seen, overflow_seen_next;

  logic                accept;
  logic                room;
  logic                out_free;
  logic                emit_fire;
  bas_cell_ctl_t       ctl;

  logic [VALUE_W-1:0]  cell_value [SORT_DEPTH];
  logic [SORT_DEPTH-1:0] cell_gt;

  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  logic                out_last;
  logic                out_ovf;

  assign src.ready = (state == ST_LOAD);
  assign accept    = src.valid && src.ready;
  assign room      = (count < COUNT_W'(SORT_DEPTH));
  assign out_free  = !out_valid || dst.ready;
  assign emit_fire = (state == ST_EMIT) && out_free;

  // Broadcast to the row: insert on a kept transaction, shift down on emission
  assign ctl.insert = accept && room;
  assign ctl.shift  = emit_fire;
  assign ctl.x      = src.value;

  always_comb begin
    state_next         = state;
    count_next         = count;
    overflow_seen_next = overflow_seen;
    unique case (state)
      ST_LOAD: begin
        if (accept) begin
          // keep while there is room, otherwise drop and flag the batch
          if (room) begin
            count_next = count + COUNT_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
          if (src.last) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          count_next = count - COUNT_W'(1);
          if (count == COUNT_W'(1)) begin
            state_next         = ST_LOAD;
            overflow_seen_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Row of cells; cell 0 holds the smallest kept value
  for (genvar i = 0; i < SORT_DEPTH; i++) begin : g_cell
    logic               prev_gt;
    logic [VALUE_W-1:0] prev_value;
    logic [VALUE_W-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_gt    = 1'b0;
      assign prev_value = '0;
    end else begin : g_mid
      assign prev_gt    = cell_gt[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == SORT_DEPTH - 1) begin : g_end
      assign next_value = '0;
    end else begin : g_inner
      assign next_value = cell_value[i+1];
    end

    bas_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (COUNT_W'(i) < count),
      .fill       (COUNT_W'(i) == count),
      .prev_gt    (prev_gt),
      .prev_value (prev_value),
      .next_value (next_value),
      .gt         (cell_gt[i]),
      .value      (cell_value[i])
    );
  end

  // Output register: load the head of the row, hold it until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_value <= cell_value[0];
      out_last  <= (count == COUNT_W'(1));
      out_ovf   <= overflow_seen;
    end
  end

  assign dst.valid        = out_valid;
  assign dst.sorted_value = out_value;
  assign dst.last_res     = out_last;
  assign dst.overflow     = out_ovf;

  // A closing transaction always leaves something to emit
  `BAS_ASSERT_NEXT(a_last_starts_emit, clk, rst, accept && src.last,
    (state == ST_EMIT) && (count != '0), "closing transaction did not start emission")

  // The final result returns control to loading with an empty row
  `BAS_ASSERT_NEXT(a_final_clears, clk, rst, emit_fire && (count == COUNT_W'(1)),
    (state == ST_LOAD) && (count == '0) && !overflow_seen, "final result left state behind")

  // Drops happen only on a full row
  `BAS_ASSERT_NOW(a_overflow_full, clk, rst, overflow_seen && (state == ST_LOAD),
    count == COUNT_W'(SORT_DEPTH), "overflow flagged on a row that is not full")

  // The head of the row stays ordered while loading
  `BAS_ASSERT_NOW(a_row_ordered, clk, rst, (state == ST_LOAD) && (count >= COUNT_W'(2)),
    cell_value[0] <= cell_value[1], "head of the row out of order")

endmodule
